/* sv/ring_finger_table_engine_defines.svh */
// Assertion helpers used by the checker file.
`ifndef RING_FINGER_TABLE_ENGINE_DEFINES_SVH
`define RING_FINGER_TABLE_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RFTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RFTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rfte_pkg.sv */
`timescale 1ns / 1ps
package rfte_pkg;

  localparam int TABLE_SLOTS = 6;
  localparam int ID_W        = 6;
  localparam int RING_SIZE   = 2 ** ID_W;
  localparam int SLOT_W      = 3;
  localparam int IP_W        = 32;
  localparam int PORT_W      = 16;
  localparam int TTL_W       = 9;
  localparam int OP_W        = 3;
  localparam int ADDR_W      = IP_W + PORT_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_JOIN   = 3'd2,
    OP_LEAVE  = 3'd3,
    OP_ROUTE  = 3'd4
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT = 2'd2;

  // Input item payload, last field in the low bits (72 bits, no padding).
  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic signed [TTL_W-1:0] ttl;
    logic [PORT_W-1:0]       node_port;
    logic [IP_W-1:0]         node_ip;
    logic [ID_W-1:0]         other_id;
    logic [ID_W-1:0]         key_id;
  } in_item_t;

  // Result payload, padded to 64 bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic [SLOT_W-1:0] result_slot;
    logic [PORT_W-1:0] result_port;
    logic [IP_W-1:0]   result_ip;
    logic [ID_W-1:0]   result_id;
  } out_item_t;

  localparam int IN_TDATA_W  = $bits(in_item_t);
  localparam int OUT_TDATA_W = $bits(out_item_t);

  typedef struct packed {
    logic              capture;
    logic              step;
    logic              emit;
    logic [SLOT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

  // Ring interval test; wraps when lo is not below hi.
  function automatic logic ring_within(input logic [ID_W-1:0] id,
                                       input logic [ID_W-1:0] lo,
                                       input logic [ID_W-1:0] hi,
                                       input logic            lo_open,
                                       input logic            hi_open);
    logic above;
    logic below;
    above = lo_open ? (id > lo) : (id >= lo);
    below = hi_open ? (id < hi) : (id <= hi);
    return (lo < hi) ? (above && below) : (above || below);
  endfunction

endpackage

/* sv/rfte_dpath.sv */
`timescale 1ns / 1ps
module rfte_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rfte_pkg::dp_cmd_t              cmd,
  output rfte_pkg::dp_stat_t             stat,
  input  logic [rfte_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [rfte_pkg::OP_W-1:0]      in_tuser,
  output logic [rfte_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [rfte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rfte_pkg::*;

  logic [ID_W-1:0]   local_id_r;
  logic [IP_W-1:0]   local_ip_r;
  logic [PORT_W-1:0] local_port_r;

  logic [ID_W-1:0]   finger_node_r [TABLE_SLOTS];
  logic [ADDR_W-1:0] finger_addr_r [TABLE_SLOTS];

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   key_r;
  logic [ID_W-1:0]   other_r;
  logic [ADDR_W-1:0] addr_r;
  logic              ttl_neg_r;
  logic [SLOT_W-1:0] slot_r;

  logic              res_found_r;
  logic [ID_W-1:0]   res_id_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [SLOT_W-1:0] res_slot_r;

  logic              out_found_r;
  logic [ID_W-1:0]   out_id_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [SLOT_W-1:0] out_slot_r;

  in_item_t          item;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] wr_idx;
  logic [ID_W-1:0]   cur_node;
  logic [ADDR_W-1:0] cur_addr;
  logic [ID_W-1:0]   pow;
  logic [ID_W-1:0]   route_lo;
  logic [ID_W-1:0]   route_hi;
  logic [ID_W-1:0]   join_lo;
  logic [ID_W-1:0]   d_new;
  logic [ID_W-1:0]   d_cur;
  logic              hit;
  logic              wr;
  logic              not_self;
  out_item_t         res_out;

  assign item = in_item_t'(in_tdata);

  // Lookup walks from the top slot down, everything else from slot 0 up.
  assign cur      = (op_r == OP_LOOKUP) ? (SLOT_W'(TABLE_SLOTS - 1) - cmd.cnt) : cmd.cnt;
  assign cur_node = finger_node_r[cur];
  assign cur_addr = finger_addr_r[cur];
  assign pow      = ID_W'(1) << cur;
  assign route_lo = local_id_r + ID_W'(1);
  assign route_hi = route_lo + pow;
  assign join_lo  = local_id_r + pow;
  assign d_new    = key_r - join_lo;
  assign d_cur    = cur_node - join_lo;
  assign not_self = (key_r != local_id_r);

  always_comb begin
    hit    = 1'b0;
    wr     = 1'b0;
    wr_idx = cur;
    case (op_r)
      OP_LOAD: begin
        wr     = (int'(slot_r) < TABLE_SLOTS);
        wr_idx = slot_r;
      end
      OP_LOOKUP: hit = ring_within(cur_node, local_id_r, key_r, 1'b1, 1'b1);
      OP_JOIN:   wr  = not_self && (d_new < d_cur);
      OP_LEAVE:  wr  = not_self && !ttl_neg_r && (cur_node == key_r);
      OP_ROUTE:  hit = !ttl_neg_r && ring_within(key_r, route_lo, route_hi, 1'b0, 1'b1);
      default: ;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_LOOKUP, OP_JOIN, OP_LEAVE, OP_ROUTE:
        stat.scan_done = hit || (cmd.cnt == SLOT_W'(TABLE_SLOTS - 1));
      default:
        stat.scan_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r   <= '0;
      local_ip_r   <= '0;
      local_port_r <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        finger_node_r[SLOT_W'(i)] <= '0;
        finger_addr_r[SLOT_W'(i)] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_ID:   local_id_r   <= cfg_data[ID_W-1:0];
          CFG_LOCAL_IP:   local_ip_r   <= cfg_data[IP_W-1:0];
          CFG_LOCAL_PORT: local_port_r <= cfg_data[PORT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step && wr) begin
        finger_node_r[wr_idx] <= (op_r == OP_JOIN) ? key_r : other_r;
        finger_addr_r[wr_idx] <= addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_tuser;
      key_r     <= item.key_id;
      other_r   <= item.other_id;
      addr_r    <= {item.node_ip, item.node_port};
      ttl_neg_r <= item.ttl[TTL_W-1];
      slot_r    <= item.slot;
      res_found_r <= 1'b0;
      res_slot_r  <= '0;
      if (in_tuser == OP_LOOKUP) begin
        res_id_r   <= local_id_r;
        res_addr_r <= {local_ip_r, local_port_r};
      end else begin
        res_id_r   <= '0;
        res_addr_r <= '0;
      end
    end else if (cmd.step && hit) begin
      res_found_r <= 1'b1;
      res_id_r    <= cur_node;
      res_addr_r  <= cur_addr;
      res_slot_r  <= cur;
    end
    if (cmd.emit) begin
      out_found_r <= res_found_r;
      out_id_r    <= res_id_r;
      out_addr_r  <= res_addr_r;
      out_slot_r  <= res_slot_r;
    end
  end

  always_comb begin
    res_out.pad         = '0;
    res_out.result_slot = out_slot_r;
    res_out.result_port = out_addr_r[PORT_W-1:0];
    res_out.result_ip   = out_addr_r[ADDR_W-1:PORT_W];
    res_out.result_id   = out_id_r;
  end

  assign out_tdata = res_out;
  assign out_tuser = out_found_r;

endmodule

/* sv/rfte_ctrl.sv */
`timescale 1ns / 1ps
module rfte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output rfte_pkg::dp_cmd_t  cmd,
  input  rfte_pkg::dp_stat_t stat
);
  import rfte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.cnt     = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end
      S_DONE: begin
        // hold the finished item until the output register is free
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/ring_finger_table_engine.sv */
`timescale 1ns / 1ps
// Finger table engine for a 64-position identifier ring with six finger slots.
// Every item (load, closest-preceding lookup, join, leave, route) yields one
// result item. The engine handles one item at a time: it takes the item, the
// scan unit visits finger slots in turn (1 for load and unused codes, up to
// 6 otherwise, stopping early on a lookup or route hit), and the result then
// moves into the output register once that register is free. A new item is
// taken while the previous result still waits in the output register.
// Configuration writes are always accepted and must only be issued while no
// item is in flight.
module ring_finger_table_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // key_id[5:0], other_id[11:6], node_ip[43:12], node_port[59:44],
  // ttl[68:60], slot[71:69]
  input  logic [rfte_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op[2:0]
  input  logic [rfte_pkg::OP_W-1:0]         in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // result_id[5:0], result_ip[37:6], result_port[53:38], result_slot[56:54],
  // zero[63:57]
  output logic [rfte_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // found[0]
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rfte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfte_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rfte_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rfte_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rfte_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* sv/rfte_checker.sv */
`timescale 1ns / 1ps
`include "ring_finger_table_engine_defines.svh"
module rfte_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [rfte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready
);

  `RFTE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `RFTE_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `RFTE_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second item taken during a scan")
  `RFTE_ASSERT_NEXT(a_no_instant_result, in_tvalid && in_tready, !$rose(out_tvalid), "result appeared before the scan ran")

endmodule

bind ring_finger_table_engine rfte_checker u_rfte_checker (.*);

/* tb/tb_ring_finger_table_engine.sv */
`timescale 1ns / 1ps
module tb_ring_finger_table_engine;
  import rfte_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 10;
  localparam int FILL_DEPTH    = 4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    in_item_t        pay;
  } item_t;

  typedef struct packed {
    logic      found;
    out_item_t d;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ring_finger_table_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the finger table and the local node registers
  logic [ID_W-1:0]   fnode [TABLE_SLOTS];
  logic [ADDR_W-1:0] faddr [TABLE_SLOTS];
  logic [ID_W-1:0]   node_id;
  logic [IP_W-1:0]   node_ip;
  logic [PORT_W-1:0] node_port;

  item_t    ops_to_send [$];
  verdict_t replies_due [$];
  item_t    drv_cur;
  verdict_t want;
  verdict_t got;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       errors = 0;
  int       n_checked = 0;
  int       n_hits = 0;
  int       op_seen [8];

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic on_arc(input logic [ID_W-1:0] x, input logic [ID_W-1:0] lo,
                                  input logic [ID_W-1:0] hi, input logic lo_incl,
                                  input logic hi_incl);
    logic past_lo;
    logic short_hi;
    past_lo  = lo_incl ? (x >= lo) : (x > lo);
    short_hi = hi_incl ? (x <= hi) : (x < hi);
    if (lo < hi) return past_lo && short_hi;
    return past_lo || short_hi;
  endfunction

  // Applies one item to the shadow table and returns the reply it causes.
  function automatic verdict_t finger_table_apply(input item_t it);
    verdict_t v;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    logic [ID_W-1:0] dnew;
    logic [ID_W-1:0] dcur;
    logic done;
    v = '0;
    done = 1'b0;
    case (it.op)
      OP_LOAD: begin
        if (it.pay.slot < TABLE_SLOTS) begin
          fnode[it.pay.slot] = it.pay.other_id;
          faddr[it.pay.slot] = {it.pay.node_ip, it.pay.node_port};
        end
      end
      OP_LOOKUP: begin
        v.d.result_id   = node_id;
        v.d.result_ip   = node_ip;
        v.d.result_port = node_port;
        for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
          if (!done && on_arc(fnode[SLOT_W'(s)], node_id, it.pay.key_id, 1'b0, 1'b0)) begin
            done = 1'b1;
            v.found         = 1'b1;
            v.d.result_id   = fnode[SLOT_W'(s)];
            v.d.result_ip   = faddr[SLOT_W'(s)][ADDR_W-1:PORT_W];
            v.d.result_port = faddr[SLOT_W'(s)][PORT_W-1:0];
            v.d.result_slot = SLOT_W'(s);
          end
        end
      end
      OP_JOIN: begin
        if (it.pay.key_id != node_id) begin
          for (int s = 0; s < TABLE_SLOTS; s++) begin
            lo   = node_id + ID_W'(1 << s);
            dnew = it.pay.key_id - lo;
            dcur = fnode[SLOT_W'(s)] - lo;
            if (dnew < dcur) begin
              fnode[SLOT_W'(s)] = it.pay.key_id;
              faddr[SLOT_W'(s)] = {it.pay.node_ip, it.pay.node_port};
            end
          end
        end
      end
      OP_LEAVE: begin
        if (it.pay.key_id != node_id && !it.pay.ttl[TTL_W-1]) begin
          for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (fnode[SLOT_W'(s)] == it.pay.key_id) begin
              fnode[SLOT_W'(s)] = it.pay.other_id;
              faddr[SLOT_W'(s)] = {it.pay.node_ip, it.pay.node_port};
            end
          end
        end
      end
      OP_ROUTE: begin
        if (!it.pay.ttl[TTL_W-1]) begin
          lo = node_id + ID_W'(1);
          for (int s = 0; s < TABLE_SLOTS; s++) begin
            hi = lo + ID_W'(1 << s);
            if (!done && on_arc(it.pay.key_id, lo, hi, 1'b1, 1'b0)) begin
              done = 1'b1;
              v.found         = 1'b1;
              v.d.result_id   = fnode[SLOT_W'(s)];
              v.d.result_ip   = faddr[SLOT_W'(s)][ADDR_W-1:PORT_W];
              v.d.result_port = faddr[SLOT_W'(s)][PORT_W-1:0];
              v.d.result_slot = SLOT_W'(s);
            end
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic item_t mk(input logic [OP_W-1:0] op, input int key, input int other,
                               input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                               input int ttl, input int slot);
    item_t it;
    it.op            = op;
    it.pay.key_id    = key[ID_W-1:0];
    it.pay.other_id  = other[ID_W-1:0];
    it.pay.node_ip   = ip;
    it.pay.node_port = port;
    it.pay.ttl       = ttl[TTL_W-1:0];
    it.pay.slot      = slot[SLOT_W-1:0];
    return it;
  endfunction

  function automatic item_t rand_item();
    int p;
    int key;
    int ttl;
    int slot;
    logic [OP_W-1:0] op;
    p = $urandom_range(0, 99);
    if (p < 18) op = OP_LOAD;
    else if (p < 42) op = OP_LOOKUP;
    else if (p < 60) op = OP_JOIN;
    else if (p < 74) op = OP_LEAVE;
    else if (p < 97) op = OP_ROUTE;
    else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    key = int'($urandom_range(0, RING_SIZE - 1));
    // steer keys towards the local node and towards ids held in the table
    if ($urandom_range(0, 99) < 8) key = int'(node_id);
    else if (op == OP_LEAVE && $urandom_range(0, 99) < 60)
      key = int'(fnode[SLOT_W'($urandom_range(0, TABLE_SLOTS - 1))]);
    else if (op == OP_ROUTE && $urandom_range(0, 99) < 40)
      key = int'(node_id) + 1 + int'($urandom_range(0, 40));
    ttl  = ($urandom_range(0, 99) < 12) ? -1 : int'($urandom_range(0, 255));
    slot = ($urandom_range(0, 99) < 6) ? int'($urandom_range(TABLE_SLOTS, 7))
                                        : int'($urandom_range(0, TABLE_SLOTS - 1));
    return mk(op, key, int'($urandom_range(0, RING_SIZE - 1)), $urandom,
              PORT_W'($urandom_range(0, 65535)), ttl, slot);
  endfunction

  task automatic queue_item(input item_t it);
    while (ops_to_send.size() >= FILL_DEPTH) @(negedge clk);
    ops_to_send = {ops_to_send, it};
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOCAL_ID:   node_id = val[ID_W-1:0];
      CFG_LOCAL_IP:   node_ip = val;
      CFG_LOCAL_PORT: node_port = val[PORT_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits of id and port words carry noise the block must drop
  task automatic set_node(input int id, input logic [IP_W-1:0] ip, input int port);
    write_reg(CFG_LOCAL_ID, ($urandom & ~32'h3f) | (id & 32'h3f));
    write_reg(CFG_LOCAL_IP, ip);
    write_reg(CFG_LOCAL_PORT, ($urandom & ~32'hffff) | (port & 32'hffff));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (ops_to_send.size() != 0 || in_tvalid || replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [IP_W-1:0] exp_v,
                             input logic [IP_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        replies_due = {replies_due, finger_table_apply(drv_cur)};
        op_seen[drv_cur.op]++;
      end
      if (!in_tvalid || in_tready) begin
        if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          drv_cur = ops_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= drv_cur.pay;
          in_tuser  <= drv_cur.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, got found %b data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = replies_due.pop_front();
          n_checked++;
          if (got.found) n_hits++;
          check_field("found", IP_W'(want.found), IP_W'(got.found));
          check_field("result_id", IP_W'(want.d.result_id), IP_W'(got.d.result_id));
          check_field("result_ip", want.d.result_ip, got.d.result_ip);
          check_field("result_port", IP_W'(want.d.result_port), IP_W'(got.d.result_port));
          check_field("result_slot", IP_W'(want.d.result_slot), IP_W'(got.d.result_slot));
          check_field("pad", IP_W'(want.d.pad), IP_W'(got.d.pad));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      fnode[SLOT_W'(s)] = '0;
      faddr[SLOT_W'(s)] = '0;
    end
    node_id   = '0;
    node_ip   = '0;
    node_port = '0;
    for (int k = 0; k < 8; k++) op_seen[OP_W'(k)] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_node(10, 32'hc0a8_0001, 16'h1f90);
    // empty table, then a full one
    queue_item(mk(OP_LOOKUP, 20, 0, 0, 0, 0, 0));
    queue_item(mk(OP_ROUTE, 11, 0, 0, 0, 0, 0));
    queue_item(mk(OP_LOAD, 0, 11, 32'h0, 16'h0, 0, 0));
    queue_item(mk(OP_LOAD, 63, 12, 32'hffff_ffff, 16'hffff, 255, 1));
    queue_item(mk(OP_LOAD, 0, 15, 32'h1234_5678, 16'h0050, 0, 2));
    queue_item(mk(OP_LOAD, 0, 63, 32'h8000_0001, 16'h8001, 0, 3));
    queue_item(mk(OP_LOAD, 0, 26, 32'h0a00_0026, 16'h0026, 0, 4));
    queue_item(mk(OP_LOAD, 0, 42, 32'h0a00_0042, 16'h0042, 0, 5));
    queue_item(mk(OP_LOAD, 0, 1, 32'hdead_beef, 16'hbeef, 0, 6));
    queue_item(mk(OP_LOAD, 0, 2, 32'hdead_beef, 16'hbeef, 0, 7));
    queue_item(mk(OP_LOOKUP, 30, 0, 0, 0, 0, 0));
    // key equal to the local id: every finger but the local one qualifies
    queue_item(mk(OP_LOOKUP, 10, 0, 0, 0, 0, 0));
    queue_item(mk(OP_LOOKUP, 11, 0, 0, 0, 0, 0));
    queue_item(mk(OP_LOOKUP, 5, 0, 0, 0, 0, 0));
    queue_item(mk(OP_ROUTE, 10, 0, 0, 0, 0, 0));
    queue_item(mk(OP_ROUTE, 11, 0, 0, 0, -1, 0));
    queue_item(mk(OP_ROUTE, 41, 0, 0, 0, 255, 0));
    queue_item(mk(OP_JOIN, 10, 0, 32'h1111_1111, 16'h1111, 0, 0));
    queue_item(mk(OP_JOIN, 13, 0, 32'h1313_1313, 16'h1313, 0, 0));
    queue_item(mk(OP_JOIN, 0, 0, 32'h0000_0100, 16'h0100, 0, 0));
    queue_item(mk(OP_LEAVE, 63, 50, 32'h5050_5050, 16'h5050, -1, 0));
    queue_item(mk(OP_LEAVE, 10, 50, 32'h5050_5050, 16'h5050, 0, 0));
    queue_item(mk(OP_LEAVE, 42, 50, 32'h5050_5050, 16'h5050, 0, 0));
    queue_item(mk(OP_LEAVE, 13, 20, 32'h2020_2020, 16'h2020, 0, 0));
    queue_item(mk(OP_SPARE_LO, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_SPARE_HI, 63, 63, 32'hffff_ffff, 16'hffff, -1, 7));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin set_node(0, 32'h0, 0); gap_pct = 0; stall_pct = 0; end
        1: begin set_node(63, 32'hffff_ffff, 16'hffff); gap_pct = 50; stall_pct = 0; end
        2: begin
          set_node($urandom_range(0, 63), $urandom, $urandom_range(0, 65535));
          gap_pct = 0;
          stall_pct = 50;
        end
        default: begin
          set_node($urandom_range(0, 63), $urandom, $urandom_range(0, 65535));
          gap_pct = 32;
          stall_pct = 32;
        end
      endcase
      repeat (150) queue_item(rand_item());
      settle();
    end

    $display("Sent %0d load, %0d lookup, %0d join, %0d leave, %0d route, %0d spare-code items;",
             op_seen[OP_LOAD], op_seen[OP_LOOKUP], op_seen[OP_JOIN], op_seen[OP_LEAVE],
             op_seen[OP_ROUTE], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("%0d replies checked (%0d hits) over five local-node settings and four idle mixes.",
             n_checked, n_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d replies outstanding", replies_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rfte_pkg.sv
sv/rfte_dpath.sv
sv/rfte_ctrl.sv
sv/ring_finger_table_engine.sv
sv/rfte_checker.sv
tb/tb_ring_finger_table_engine.sv
